// ===== hw/rtl/sbp_pkg.sv =====
// Shared types, codes and the CRC-16 CCITT byte update for the SBP frame receiver.
// Used by sbp_rx_fsm, sbp_frame_receiver_core and sbp_checker; depends on nothing.
`default_nettype none

package sbp_pkg;

	localparam logic [7:0] PREAMBLE = 8'h55;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] MEAS_TYPE_RESET = 16'd2;
	localparam int CAPTURE_LEN = 13;
	localparam int CAP_IDX_W = $clog2(CAPTURE_LEN);

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_MEAS = 2'd1,
		KIND_OTHER = 2'd2,
		KIND_CRC_ERR = 2'd3
	} sbp_kind_t;

	typedef enum logic [5:0] {
		PH_WAIT = 6'b000001,
		PH_TYPE = 6'b000010,
		PH_SENDER = 6'b000100,
		PH_LEN = 6'b001000,
		PH_MSG = 6'b010000,
		PH_CRC = 6'b100000
	} sbp_phase_t;

	typedef struct packed {
		logic valid;
		sbp_kind_t kind;
		logic [7:0] payload_byte;
		logic [15:0] frame_type;
		logic [15:0] frame_sender;
		logic [7:0] frame_length;
		logic [31:0] distance;
		logic [7:0] quality;
		logic [15:0] meas_sender;
		logic [15:0] reflector;
		logic [31:0] meas_time;
	} sbp_result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sbp_rx_fsm.sv =====
// Frame parser: phase sequencer, header and CRC registers, measurement capture.
// Depends on sbp_pkg; advances by one byte whenever step is high.
`default_nettype none

module sbp_rx_fsm (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic [7:0] rx_byte,
	input wire logic [15:0] meas_type,
	output sbp_pkg::sbp_result_t result
);

	sbp_pkg::sbp_phase_t phase_q;
	logic [7:0] byte_count_q;
	logic [15:0] type_q;
	logic [15:0] sender_q;
	logic [7:0] length_q;
	logic [15:0] crc_q;
	logic [7:0] rcv_crc_lo_q;
	logic [7:0] cap_q [sbp_pkg::CAPTURE_LEN];

	logic [15:0] crc_upd;
	logic [7:0] count_inc;

	assign crc_upd = sbp_pkg::crc16_byte(crc_q, rx_byte);
	assign count_inc = byte_count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbp_pkg::PH_WAIT;
			byte_count_q <= '0;
			type_q <= '0;
			sender_q <= '0;
			length_q <= '0;
			crc_q <= '0;
			rcv_crc_lo_q <= '0;
			for (int i = 0; i < sbp_pkg::CAPTURE_LEN; i++) begin
				cap_q[i] <= '0;
			end
		end else if (step) begin
			case (phase_q)
				sbp_pkg::PH_WAIT: begin
					if (rx_byte == sbp_pkg::PREAMBLE) begin
						for (int i = 0; i < sbp_pkg::CAPTURE_LEN; i++) begin
							cap_q[i] <= '0;
						end
						crc_q <= '0;
						byte_count_q <= '0;
						phase_q <= sbp_pkg::PH_TYPE;
					end
				end
				sbp_pkg::PH_TYPE: begin
					crc_q <= crc_upd;
					if (byte_count_q == 8'd0) begin
						type_q[7:0] <= rx_byte;
						byte_count_q <= 8'd1;
					end else begin
						type_q[15:8] <= rx_byte;
						byte_count_q <= '0;
						phase_q <= sbp_pkg::PH_SENDER;
					end
				end
				sbp_pkg::PH_SENDER: begin
					crc_q <= crc_upd;
					if (byte_count_q == 8'd0) begin
						sender_q[7:0] <= rx_byte;
						byte_count_q <= 8'd1;
					end else begin
						sender_q[15:8] <= rx_byte;
						byte_count_q <= '0;
						phase_q <= sbp_pkg::PH_LEN;
					end
				end
				sbp_pkg::PH_LEN: begin
					crc_q <= crc_upd;
					length_q <= rx_byte;
					byte_count_q <= '0;
					phase_q <= (rx_byte != 8'd0) ? sbp_pkg::PH_MSG : sbp_pkg::PH_CRC;
				end
				sbp_pkg::PH_MSG: begin
					crc_q <= crc_upd;
					if (byte_count_q < 8'(sbp_pkg::CAPTURE_LEN)) begin
						cap_q[byte_count_q[sbp_pkg::CAP_IDX_W-1:0]] <= rx_byte;
					end
					if (count_inc == length_q) begin
						byte_count_q <= '0;
						phase_q <= sbp_pkg::PH_CRC;
					end else begin
						byte_count_q <= count_inc;
					end
				end
				sbp_pkg::PH_CRC: begin
					if (byte_count_q == 8'd0) begin
						rcv_crc_lo_q <= rx_byte;
						byte_count_q <= 8'd1;
					end else begin
						byte_count_q <= '0;
						phase_q <= sbp_pkg::PH_WAIT;
					end
				end
				default: begin
					byte_count_q <= '0;
					phase_q <= sbp_pkg::PH_WAIT;
				end
			endcase
		end
	end

	always_comb begin
		result = '0;
		result.frame_type = type_q;
		result.frame_sender = sender_q;
		result.frame_length = length_q;
		case (phase_q)
			sbp_pkg::PH_MSG: begin
				result.valid = 1'b1;
				result.kind = sbp_pkg::KIND_PAYLOAD;
				result.payload_byte = rx_byte;
			end
			sbp_pkg::PH_CRC: begin
				if (byte_count_q != 8'd0) begin
					result.valid = 1'b1;
					if ({rx_byte, rcv_crc_lo_q} != crc_q) begin
						result.kind = sbp_pkg::KIND_CRC_ERR;
					end else if (type_q == meas_type) begin
						result.kind = sbp_pkg::KIND_MEAS;
						result.distance = {cap_q[3], cap_q[2], cap_q[1], cap_q[0]};
						result.quality = cap_q[4];
						result.meas_sender = {cap_q[6], cap_q[5]};
						result.reflector = {cap_q[8], cap_q[7]};
						result.meas_time = {cap_q[12], cap_q[11], cap_q[10], cap_q[9]};
					end else begin
						result.kind = sbp_pkg::KIND_OTHER;
					end
				end
			end
			default: begin
				result.valid = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sbp_frame_receiver_core.sv =====
// Top level of the SBP frame receiver: input register, result register, config register.
// Depends on sbp_pkg and sbp_rx_fsm.
//
// Channel   Handshake              Payload
// input     in_valid / in_stall    rx_byte
// output    out_valid / out_stall  kind, payload_byte, frame_*, distance .. meas_time
// config    cfg_valid / cfg_ready  measurement_type
//
// One byte is taken per cycle while in_stall is low; results come from the result register.
// The parser steps once per byte between the input register and the result register.
// Reset is asynchronous and returns the parser to preamble search with the type register at 2.
// A stalled result holds, and the input stalls only when both registers are full.
`default_nettype none

module sbp_frame_receiver_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [15:0] frame_type,
	output logic [15:0] frame_sender,
	output logic [7:0] frame_length,
	output logic [31:0] distance,
	output logic [7:0] quality,
	output logic [15:0] meas_sender,
	output logic [15:0] reflector,
	output logic [31:0] meas_time,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [15:0] measurement_type
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic [15:0] meas_type_q;
	logic out_valid_q;
	sbp_pkg::sbp_result_t result_q;
	sbp_pkg::sbp_result_t step_result;
	logic step;

	assign step = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			meas_type_q <= sbp_pkg::MEAS_TYPE_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				meas_type_q <= measurement_type;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (step) begin
				out_valid_q <= step_result.valid;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
		if (step && step_result.valid) begin
			result_q <= step_result;
		end
	end

	sbp_rx_fsm u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rx_byte(byte_s1),
		.meas_type(meas_type_q),
		.result(step_result)
	);

	assign out_valid = out_valid_q;
	assign kind = result_q.kind;
	assign payload_byte = result_q.payload_byte;
	assign frame_type = result_q.frame_type;
	assign frame_sender = result_q.frame_sender;
	assign frame_length = result_q.frame_length;
	assign distance = result_q.distance;
	assign quality = result_q.quality;
	assign meas_sender = result_q.meas_sender;
	assign reflector = result_q.reflector;
	assign meas_time = result_q.meas_time;

endmodule

`default_nettype wire

// ===== hw/rtl/sbp_checker.sv =====
// Port-level checks for sbp_frame_receiver_core, bound to every instance of it.
// Depends on sbp_pkg for the result kind codes.
`default_nettype none

module sbp_core_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] payload_byte,
	input wire logic [7:0] frame_length,
	input wire logic [31:0] distance,
	input wire logic [7:0] quality,
	input wire logic [15:0] meas_sender,
	input wire logic [15:0] reflector,
	input wire logic [31:0] meas_time
);

	// A payload transaction can only come from a frame with a nonzero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == sbp_pkg::KIND_PAYLOAD) |-> frame_length != 8'd0)
		else $error("payload byte reported for a zero-length frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != sbp_pkg::KIND_PAYLOAD) |-> payload_byte == 8'd0)
		else $error("payload byte not zero on a frame status");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != sbp_pkg::KIND_MEAS) |->
		(distance == 32'd0 && quality == 8'd0 && meas_sender == 16'd0 &&
		reflector == 16'd0 && meas_time == 32'd0))
		else $error("measurement fields set outside a measurement frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(payload_byte)))
		else $error("stalled result changed");

endmodule

bind sbp_frame_receiver_core sbp_core_props u_sbp_core_props (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind(kind),
	.payload_byte(payload_byte),
	.frame_length(frame_length),
	.distance(distance),
	.quality(quality),
	.meas_sender(meas_sender),
	.reflector(reflector),
	.meas_time(meas_time)
);

`default_nettype wire

// ===== bench/sbp_checker.sv =====
// Watches the byte, result and configuration channels of sbp_frame_receiver_core,
// predicts each result of the deframer and compares it field by field.
// Depends on sbp_pkg for the result record, kind codes, phase codes and constants.
module sbp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [7:0] rx_byte,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] payload_byte,
	input wire logic [15:0] frame_type,
	input wire logic [15:0] frame_sender,
	input wire logic [7:0] frame_length,
	input wire logic [31:0] distance,
	input wire logic [7:0] quality,
	input wire logic [15:0] meas_sender,
	input wire logic [15:0] reflector,
	input wire logic [31:0] meas_time,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [15:0] measurement_type,
	output int pending,
	output int mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbp_pkg::*;

	sbp_phase_t parse_phase;
	logic [7:0] field_count;
	logic [15:0] hdr_type;
	logic [15:0] hdr_sender;
	logic [7:0] hdr_length;
	logic [15:0] crc_acc;
	logic [15:0] crc_seen;
	logic [7:0] meas_bytes [CAPTURE_LEN];
	logic [15:0] meas_type_setting;
	sbp_result_t awaited_results [$];
	int error_count = 0;

	assign mismatches = error_count;

	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] acc;
		logic feedback;
		acc = crc;
		for (int i = 7; i >= 0; i--) begin
			feedback = acc[15] ^ d[i];
			acc = {acc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
		end
		return acc;
	endfunction

	function automatic sbp_result_t frame_result(input sbp_kind_t k, input logic [7:0] pb);
		sbp_result_t r;
		r = '0;
		r.valid = 1'b1;
		r.kind = k;
		r.payload_byte = pb;
		r.frame_type = hdr_type;
		r.frame_sender = hdr_sender;
		r.frame_length = hdr_length;
		if (k == KIND_MEAS) begin
			r.distance = {meas_bytes[3], meas_bytes[2], meas_bytes[1], meas_bytes[0]};
			r.quality = meas_bytes[4];
			r.meas_sender = {meas_bytes[6], meas_bytes[5]};
			r.reflector = {meas_bytes[8], meas_bytes[7]};
			r.meas_time = {meas_bytes[12], meas_bytes[11], meas_bytes[10], meas_bytes[9]};
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		error_count++;
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report(what, got, want);
		end
	endtask

	task automatic advance_deframer(input logic [7:0] b);
		case (parse_phase)
			PH_WAIT: begin
				if (b == PREAMBLE) begin
					foreach (meas_bytes[i]) meas_bytes[i] = 8'h00;
					crc_acc = 16'h0000;
					field_count = 8'd0;
					parse_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				crc_acc = crc_ccitt_step(crc_acc, b);
				if (field_count == 8'd0) begin
					hdr_type[7:0] = b;
					field_count = 8'd1;
				end else begin
					hdr_type[15:8] = b;
					field_count = 8'd0;
					parse_phase = PH_SENDER;
				end
			end
			PH_SENDER: begin
				crc_acc = crc_ccitt_step(crc_acc, b);
				if (field_count == 8'd0) begin
					hdr_sender[7:0] = b;
					field_count = 8'd1;
				end else begin
					hdr_sender[15:8] = b;
					field_count = 8'd0;
					parse_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				crc_acc = crc_ccitt_step(crc_acc, b);
				hdr_length = b;
				field_count = 8'd0;
				parse_phase = (b != 8'd0) ? PH_MSG : PH_CRC;
			end
			PH_MSG: begin
				crc_acc = crc_ccitt_step(crc_acc, b);
				if (field_count < CAPTURE_LEN) begin
					meas_bytes[field_count] = b;
				end
				awaited_results.push_back(frame_result(KIND_PAYLOAD, b));
				field_count = field_count + 8'd1;
				if (field_count == hdr_length) begin
					field_count = 8'd0;
					parse_phase = PH_CRC;
				end
			end
			PH_CRC: begin
				if (field_count == 8'd0) begin
					crc_seen[7:0] = b;
					field_count = 8'd1;
				end else begin
					crc_seen[15:8] = b;
					field_count = 8'd0;
					parse_phase = PH_WAIT;
					if (crc_seen != crc_acc) begin
						awaited_results.push_back(frame_result(KIND_CRC_ERR, 8'h00));
					end else if (hdr_type == meas_type_setting) begin
						awaited_results.push_back(frame_result(KIND_MEAS, 8'h00));
					end else begin
						awaited_results.push_back(frame_result(KIND_OTHER, 8'h00));
					end
				end
			end
			default: begin
				parse_phase = PH_WAIT;
				field_count = 8'd0;
			end
		endcase
	endtask

	task automatic compare_result();
		sbp_result_t want;
		if (awaited_results.size() == 0) begin
			report("result with no expectation, kind", 32'(kind), 32'h0);
		end else begin
			want = awaited_results.pop_front();
			check_field("kind", 32'(kind), 32'(want.kind));
			check_field("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
			check_field("frame_type", 32'(frame_type), 32'(want.frame_type));
			check_field("frame_sender", 32'(frame_sender), 32'(want.frame_sender));
			check_field("frame_length", 32'(frame_length), 32'(want.frame_length));
			check_field("distance", distance, want.distance);
			check_field("quality", 32'(quality), 32'(want.quality));
			check_field("meas_sender", 32'(meas_sender), 32'(want.meas_sender));
			check_field("reflector", 32'(reflector), 32'(want.reflector));
			check_field("meas_time", meas_time, want.meas_time);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_phase = PH_WAIT;
			field_count = 8'd0;
			hdr_type = 16'h0000;
			hdr_sender = 16'h0000;
			hdr_length = 8'd0;
			crc_acc = 16'h0000;
			crc_seen = 16'h0000;
			foreach (meas_bytes[i]) meas_bytes[i] = 8'h00;
			meas_type_setting = MEAS_TYPE_RESET;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				meas_type_setting = measurement_type;
			end
			if (out_valid && !out_stall) begin
				compare_result();
			end
			if (in_valid && !in_stall) begin
				advance_deframer(rx_byte);
			end
			pending <= awaited_results.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench for sbp_frame_receiver_core: clock, reset, frame stimulus,
// result back-pressure, measurement type writes and the verdict.
// Depends on sbp_pkg, sbp_frame_receiver_core and sbp_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sbp_pkg::*;

	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 3000;
	localparam int PHASE_BYTES = 360;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [15:0] frame_type;
	logic [15:0] frame_sender;
	logic [7:0] frame_length;
	logic [31:0] distance;
	logic [7:0] quality;
	logic [15:0] meas_sender;
	logic [15:0] reflector;
	logic [31:0] meas_time;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_type = 16'h0000;

	int pending;
	int mismatches;
	int idle_cycles = 0;
	int frame_bytes_sent = 0;
	int big_frames = 0;
	logic [15:0] cur_type = MEAS_TYPE_RESET;
	logic tx_quiet = 1'b0;
	logic long_hold = 1'b0;
	logic [7:0] payload_q [$];

	sbp_frame_receiver_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.payload_byte(payload_byte),
		.frame_type(frame_type),
		.frame_sender(frame_sender),
		.frame_length(frame_length),
		.distance(distance),
		.quality(quality),
		.meas_sender(meas_sender),
		.reflector(reflector),
		.meas_time(meas_time),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.measurement_type(cfg_type)
	);

	sbp_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.payload_byte(payload_byte),
		.frame_type(frame_type),
		.frame_sender(frame_sender),
		.frame_length(frame_length),
		.distance(distance),
		.quality(quality),
		.meas_sender(meas_sender),
		.reflector(reflector),
		.meas_time(meas_time),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.measurement_type(cfg_type),
		.pending(pending),
		.mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] frame_crc(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] acc;
		acc = crc ^ {d, 8'h00};
		repeat (8) begin
			acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
		end
		return acc;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		int r;
		int gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 55) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(1, 3);
		end else if (r < 97) begin
			gap = $urandom_range(4, 10);
		end else begin
			gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_meas_type(input logic [15:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_type <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_type = v;
	endtask

	task automatic send_frame(input logic [15:0] typ, input logic [15:0] snd,
			input logic bad_crc, input int cut_at);
		logic [7:0] seq [$];
		logic [15:0] crc;
		seq = {PREAMBLE, typ[7:0], typ[15:8], snd[7:0], snd[15:8], 8'(payload_q.size())};
		foreach (payload_q[k]) seq.push_back(payload_q[k]);
		crc = 16'h0000;
		for (int k = 1; k < seq.size(); k++) begin
			crc = frame_crc(crc, seq[k]);
		end
		if (bad_crc) begin
			crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		end
		seq.push_back(crc[7:0]);
		seq.push_back(crc[15:8]);
		if (cut_at > 0) begin
			while (seq.size() > cut_at) void'(seq.pop_back());
		end
		foreach (seq[k]) push_byte(seq[k]);
		frame_bytes_sent += seq.size();
	endtask

	task automatic random_frame();
		int r;
		int len;
		int cut;
		logic [15:0] typ;
		logic [7:0] nb;
		tx_quiet = ($urandom_range(0, 6) == 0);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				do nb = 8'($urandom); while (nb == PREAMBLE);
				push_byte(nb);
			end
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			typ = cur_type;
		end else if (r < 52) begin
			typ = 16'h0000;
		end else if (r < 59) begin
			typ = 16'hFFFF;
		end else begin
			typ = 16'($urandom);
		end
		r = $urandom_range(0, 99);
		if (r < 10) begin
			len = 0;
		end else if (r < 70) begin
			len = $urandom_range(1, 16);
		end else if (r < 95) begin
			len = $urandom_range(17, 40);
		end else if (r < 99 || big_frames >= 2) begin
			len = $urandom_range(41, 100);
		end else begin
			len = 255;
			big_frames++;
		end
		payload_q.delete();
		repeat (len) payload_q.push_back(8'($urandom));
		cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, len + 8) : 0;
		send_frame(typ, 16'($urandom), $urandom_range(0, 6) == 0, cut);
		tx_quiet = 1'b0;
	endtask

	always begin
		int run_left;
		logic run_stall;
		int r;
		@(posedge clk);
		if (long_hold) begin
			out_stall <= 1'b1;
			repeat (LONG_HOLD) @(posedge clk);
			long_hold = 1'b0;
			run_left = 0;
		end
		if (run_left <= 0) begin
			r = $urandom_range(0, 19);
			if (r < 2) begin
				run_stall = 1'b0;
				run_left = $urandom_range(40, 150);
			end else if (r < 3) begin
				run_stall = 1'b1;
				run_left = $urandom_range(20, 60);
			end else if (r < 10) begin
				run_stall = 1'b1;
				run_left = $urandom_range(1, 3);
			end else begin
				run_stall = 1'b0;
				run_left = $urandom_range(1, 6);
			end
		end
		out_stall <= run_stall;
		run_left--;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] settings [5];
		int phase_start;
		logic held;
		settings = '{MEAS_TYPE_RESET, 16'h0000, 16'hFFFF, 16'($urandom), MEAS_TYPE_RESET};
		held = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Noise while hunting, then a zero-length measurement frame whose fields read as zero,
		// a one-byte frame carrying the preamble value, and a zero-length frame with a bad CRC.
		push_byte(8'h00);
		push_byte(8'hFF);
		payload_q.delete();
		send_frame(MEAS_TYPE_RESET, 16'hFFFF, 1'b0, 0);
		payload_q = {PREAMBLE};
		send_frame(16'hFFFF, 16'h0000, 1'b0, 0);
		payload_q.delete();
		send_frame(16'h0000, 16'h8001, 1'b1, 0);

		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				write_meas_type(settings[p]);
			end
			phase_start = frame_bytes_sent;
			while (frame_bytes_sent - phase_start < PHASE_BYTES) begin
				if (p == 2 && !held && frame_bytes_sent - phase_start > 100) begin
					held = 1'b1;
					long_hold = 1'b1;
					payload_q.delete();
					repeat (60) payload_q.push_back(8'($urandom));
					send_frame(cur_type, 16'($urandom), 1'b0, 0);
				end
				random_frame();
				if ($urandom_range(0, 29) == 0) begin
					settle();
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
